@@ rtl/mandelbrot_escape_time_macros.svh @@
// Assertion macros for the escape-time block checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, off while in reset
`define MET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/met_pkg.sv @@
// Shared types, constants and saturating helpers for the escape-time block.
// Used by met_mul and mandelbrot_escape_time; depends on nothing.
`default_nettype none
package met_pkg;

	typedef logic [63:0]  word_t;
	typedef logic [127:0] prod_t;
	typedef logic [62:0]  umag_t;

	localparam word_t SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam word_t SMIN    = 64'h8000_0000_0000_0000;
	localparam umag_t MAG_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic  go;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		prod_t product;
	} mul_rsp_t;

	// magnitude of a two's complement word; the most negative value gives 2^63
	function automatic word_t mag64(word_t v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// apply sign to an already shifted magnitude, saturate to the signed range
	function automatic word_t sat_prod(prod_t r, logic neg);
		word_t m;
		m = r[63:0];
		if (|r[127:63])
			return neg ? SMIN : SMAX;
		return neg ? (~m + 64'd1) : m;
	endfunction

	function automatic word_t add_sat(word_t a, word_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic word_t sub_sat(word_t a, word_t b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	// shifted square clamped to the unsigned 63-bit range
	function automatic umag_t sat_sq(prod_t r);
		return (|r[127:63]) ? MAG_MAX : r[62:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/mandelbrot_escape_time.sv @@
// Each iteration runs three 64x64 products through the single 32x32 multiplier,
// four passes each.
// Throughput: one pixel at a time; busy stays high until the done cycle, and a new
// start is taken in the done cycle. Results show for one cycle and cannot be stalled.
// Reset (arst_n, asynchronous) idles the sequencer and loads the default view:
// center -0.75 + 0i, step 2/600, limit 200, bailout 256.
`default_nettype none
module mandelbrot_escape_time import met_pkg::*; #(
	parameter int IMAGE_WIDTH  = 800,
	parameter int IMAGE_HEIGHT = 600
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [9:0]  column,
	input  wire  [9:0]  row,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [63:0] cfg_data,
	output logic        done,
	output logic [9:0]  out_column,
	output logic [9:0]  out_row,
	output logic [15:0] iteration_count,
	output logic        in_set,
	output logic [62:0] magnitude_sq
);

	localparam int MAX_SIZE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
	localparam int D_W      = ((SIZE_W > 11) ? SIZE_W : 11) + 1;

	localparam logic [2:0] REG_CENTER_REAL = 3'd0;
	localparam logic [2:0] REG_CENTER_IMAG = 3'd1;
	localparam logic [2:0] REG_PIXEL_STEP  = 3'd2;
	localparam logic [2:0] REG_MAX_ITER    = 3'd3;
	localparam logic [2:0] REG_BAILOUT     = 3'd4;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OFFX = 4'd1;
	localparam logic [3:0] S_X0   = 4'd2;
	localparam logic [3:0] S_OFFY = 4'd3;
	localparam logic [3:0] S_Y0   = 4'd4;
	localparam logic [3:0] S_XY   = 4'd5;
	localparam logic [3:0] S_UPD  = 4'd6;
	localparam logic [3:0] S_GSQX = 4'd7;
	localparam logic [3:0] S_WSQX = 4'd8;
	localparam logic [3:0] S_WSQY = 4'd9;
	localparam logic [3:0] S_CHK  = 4'd10;

	// configuration
	word_t       center_real_q;
	word_t       center_imag_q;
	umag_t       pixel_step_q;
	logic [15:0] max_iter_q;
	umag_t       bailout_q;

	logic [3:0]  state_q;
	logic        done_q;
	logic [15:0] count_q;
	logic [15:0] limit_q;
	logic [9:0]  column_q;
	logic [9:0]  row_q;
	logic        neg_q;
	word_t       term_q;
	word_t       x0_q;
	word_t       y0_q;
	word_t       x_q;
	word_t       y_q;
	umag_t       xsq_q;
	umag_t       ysq_q;
	logic [9:0]  out_column_q;
	logic [9:0]  out_row_q;
	logic [15:0] out_count_q;
	logic        out_in_set_q;
	umag_t       out_mag_q;

	mul_req_t    req;
	mul_rsp_t    rsp;

	logic [D_W-1:0] dx;
	logic [D_W-1:0] dy;
	logic [D_W-1:0] dx_mag;
	logic [D_W-1:0] dy_mag;
	logic [63:0]    msum;
	umag_t          mag_c;
	logic           cont;
	word_t          xy_diff;

	// pixel offset numerator: 2*pos - size keeps the half pixel of odd sizes
	assign dx     = D_W'({column, 1'b0}) - D_W'(IMAGE_WIDTH);
	assign dy     = D_W'({row_q, 1'b0}) - D_W'(IMAGE_HEIGHT);
	assign dx_mag = dx[D_W-1] ? (~dx + D_W'(1)) : dx;
	assign dy_mag = dy[D_W-1] ? (~dy + D_W'(1)) : dy;

	assign msum    = {1'b0, xsq_q} + {1'b0, ysq_q};
	assign mag_c   = msum[63] ? MAG_MAX : msum[62:0];
	assign cont    = (mag_c < bailout_q) && (count_q < limit_q);
	assign xy_diff = {1'b0, xsq_q} - {1'b0, ysq_q};

	always_comb begin
		req.go = 1'b0;
		req.a  = mag64(x_q);
		req.b  = mag64(y_q);
		unique case (state_q)
			S_IDLE: begin
				req.go = start;
				req.a  = {{(64-D_W){1'b0}}, dx_mag};
				req.b  = {1'b0, pixel_step_q};
			end
			S_X0: begin
				req.go = 1'b1;
				req.a  = {{(64-D_W){1'b0}}, dy_mag};
				req.b  = {1'b0, pixel_step_q};
			end
			S_Y0: begin
				req.go = 1'b1;
			end
			S_GSQX: begin
				req.go = 1'b1;
				req.b  = mag64(x_q);
			end
			S_WSQX: begin
				req.go = rsp.done;
				req.a  = mag64(y_q);
			end
			S_CHK: begin
				req.go = cont;
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

	met_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			count_q       <= 16'd0;
			center_real_q <= 64'hFFF4_0000_0000_0000;
			center_imag_q <= 64'd0;
			pixel_step_q  <= 63'd15011998757901;
			max_iter_q    <= 16'd200;
			bailout_q     <= 63'h1000_0000_0000_0000;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER_REAL: center_real_q <= cfg_data;
					REG_CENTER_IMAG: center_imag_q <= cfg_data;
					REG_PIXEL_STEP:  pixel_step_q  <= cfg_data[62:0];
					REG_MAX_ITER:    max_iter_q    <= cfg_data[15:0];
					REG_BAILOUT:     bailout_q     <= cfg_data[62:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_OFFX;
						count_q <= 16'd0;
					end
				end
				S_OFFX: if (rsp.done) state_q <= S_X0;
				S_X0:   state_q <= S_OFFY;
				S_OFFY: if (rsp.done) state_q <= S_Y0;
				S_Y0:   state_q <= S_XY;
				S_XY:   if (rsp.done) state_q <= S_UPD;
				S_UPD: begin
					count_q <= count_q + 16'd1;
					state_q <= S_GSQX;
				end
				S_GSQX: state_q <= S_WSQX;
				S_WSQX: if (rsp.done) state_q <= S_WSQY;
				S_WSQY: if (rsp.done) state_q <= S_CHK;
				S_CHK: begin
					if (cont) begin
						state_q <= S_XY;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					column_q <= column;
					row_q    <= row;
					limit_q  <= (max_iter_q == 16'd0) ? 16'd1 : max_iter_q;
					neg_q    <= dx[D_W-1];
					x_q      <= '0;
					y_q      <= '0;
					xsq_q    <= '0;
					ysq_q    <= '0;
				end
			end
			S_OFFX: if (rsp.done) term_q <= sat_prod(rsp.product >> 1, neg_q);
			S_X0: begin
				x0_q  <= add_sat(term_q, center_real_q);
				neg_q <= dy[D_W-1];
			end
			S_OFFY: if (rsp.done) term_q <= sat_prod(rsp.product >> 1, neg_q);
			S_Y0: begin
				// a 65-bit difference covers the most negative center as well
				y0_q  <= sub_sat(term_q, center_imag_q);
				neg_q <= x_q[63] ^ y_q[63];
			end
			S_XY: if (rsp.done) term_q <= sat_prod(rsp.product >> 51, neg_q);
			S_UPD: begin
				y_q <= add_sat(term_q, y0_q);
				x_q <= add_sat(xy_diff, x0_q);
			end
			S_WSQX: if (rsp.done) xsq_q <= sat_sq(rsp.product >> 52);
			S_WSQY: if (rsp.done) ysq_q <= sat_sq(rsp.product >> 52);
			S_CHK: begin
				neg_q <= x_q[63] ^ y_q[63];
				if (!cont) begin
					out_column_q <= column_q;
					out_row_q    <= row_q;
					out_count_q  <= count_q;
					out_in_set_q <= (count_q == limit_q);
					out_mag_q    <= mag_c;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign out_column      = out_column_q;
	assign out_row         = out_row_q;
	assign iteration_count = out_count_q;
	assign in_set          = out_in_set_q;
	assign magnitude_sq    = out_mag_q;

endmodule
`default_nettype wire

@@ rtl/met_mul.sv @@
// Shared 64x64 multiplier: one 32x32 multiplier stepped over four partial products.
// Depends on met_pkg for the request and response words.
`default_nettype none
module met_mul import met_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic        run_q;
	logic [1:0]  cnt_q;
	word_t       a_q;
	word_t       b_q;
	logic [63:0] pp_s1;
	logic [1:0]  off_s1;
	logic        pv_s1;
	logic        last_s1;
	logic        done_q;
	prod_t       acc_q;

	logic [31:0] a_half;
	logic [31:0] b_half;
	prod_t       addend;

	// order: a0*b0, a0*b1, a1*b0, a1*b1
	assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (off_s1)
			2'd0:    addend = {64'd0, pp_s1};
			2'd1:    addend = {32'd0, pp_s1, 32'd0};
			2'd2:    addend = {pp_s1, 64'd0};
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= 2'd0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_s1   <= run_q;
			last_s1 <= run_q && (cnt_q == 2'd3);
			done_q  <= pv_s1 && last_s1;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		pp_s1  <= a_half * b_half;
		off_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		if (req.go)
			acc_q <= '0;
		else if (pv_s1)
			acc_q <= acc_q + addend;
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
`default_nettype wire

@@ rtl/met_checker.sv @@
// Port-level checks on the escape-time block, attached by bind.
// Depends on mandelbrot_escape_time_macros.svh.
`default_nettype none
`include "mandelbrot_escape_time_macros.svh"
module met_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [15:0] iteration_count
);

	`MET_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
	`MET_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	`MET_ASSERT_NOW(a_busy_fall, $fell(busy), done, "busy dropped without a result")
	`MET_ASSERT_NEXT(a_done_once, done, !done, "result strobe held more than one cycle")
	`MET_ASSERT_NOW(a_count_nonzero, done, iteration_count != 16'd0, "zero iteration count")

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (.*);
`default_nettype wire
